/* rtl/bez_pkg.sv */
// shared constants, codes and helper functions for the bezier curve evaluator
// no dependencies; used by bez_store, bez_mul, bezier_bernstein_curve_eval and the testbench
package bez_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int PT_W    = 32;
    localparam int Q_W     = 31;
    localparam int WGT_W   = 29;
    localparam int ACC_W   = 64;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int STEP_W  = 17;
    localparam int SWEEP_W = 18;
    localparam int BINOM_W = MAX_POINTS;

    localparam logic [STEP_W-1:0]  STEP_RESET = 17'd655;
    localparam logic [SWEEP_W-1:0] ONE_Q16    = 18'h1_0000;
    localparam logic [Q_W-1:0]     ONE_Q30    = 31'h4000_0000;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_NEXT    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] ST_VALID      = 2'd0;
    localparam logic [1:0] ST_NO_POINTS  = 2'd1;
    localparam logic [1:0] ST_SWEEP_DONE = 2'd2;

    typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] t_binom_tbl;

    // pascal triangle, rows are the degree
    function automatic t_binom_tbl build_binom();
        t_binom_tbl tbl;
        int r;
        int c;
        tbl = '0;
        for (r = 0; r < MAX_POINTS; r++) begin
            tbl[r][0] = BINOM_W'(1);
            for (c = 1; c <= r; c++) begin
                if (c < r) begin
                    tbl[r][c] = tbl[r-1][c-1] + tbl[r-1][c];
                end else begin
                    tbl[r][c] = tbl[r-1][c-1];
                end
            end
        end
        return tbl;
    endfunction

    localparam t_binom_tbl BINOM_TBL = build_binom();

    // round Q20.44 accumulator to Q16.16 and saturate
    function automatic logic [PT_W-1:0] finish(logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] ua;
        logic [ACC_W-1:0] s;
        logic signed [36:0] r;
        logic [PT_W-1:0] res;
        ua = acc ^ {1'b1, {(ACC_W-1){1'b0}}};
        s  = ua + ACC_W'(64'h0800_0000);
        r  = $signed({1'b0, s[ACC_W-1:28]}) - $signed(37'h08_0000_0000);
        if (r > $signed(37'h00_7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
        end else if (r < $signed(37'h1F_8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = r[PT_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/bez_mul.sv */
// shared signed multiplier with registered product
// depends on bez_pkg for operand width
module bez_mul (
    input  logic                                i_clk,
    input  logic signed [bez_pkg::MUL_W-1:0]    i_a,
    input  logic signed [bez_pkg::MUL_W-1:0]    i_b,
    output logic signed [bez_pkg::PROD_W-1:0]   o_prod
);

    logic signed [bez_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/bez_store.sv */
// control point memory, x y z, one write and one registered read port
// depends on bez_pkg for depth and widths
module bez_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [bez_pkg::IDX_W-1:0]         i_waddr,
    input  logic signed [bez_pkg::PT_W-1:0]   i_wdata_x,
    input  logic signed [bez_pkg::PT_W-1:0]   i_wdata_y,
    input  logic signed [bez_pkg::PT_W-1:0]   i_wdata_z,
    input  logic [bez_pkg::IDX_W-1:0]         i_raddr,
    output logic signed [bez_pkg::PT_W-1:0]   o_rdata_x,
    output logic signed [bez_pkg::PT_W-1:0]   o_rdata_y,
    output logic signed [bez_pkg::PT_W-1:0]   o_rdata_z
);

    logic signed [bez_pkg::PT_W-1:0] r_mem_x [bez_pkg::MAX_POINTS];
    logic signed [bez_pkg::PT_W-1:0] r_mem_y [bez_pkg::MAX_POINTS];
    logic signed [bez_pkg::PT_W-1:0] r_mem_z [bez_pkg::MAX_POINTS];
    logic signed [bez_pkg::PT_W-1:0] r_rdata_x;
    logic signed [bez_pkg::PT_W-1:0] r_rdata_y;
    logic signed [bez_pkg::PT_W-1:0] r_rdata_z;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wdata_x;
            r_mem_y[i_waddr] <= i_wdata_y;
            r_mem_z[i_waddr] <= i_wdata_z;
        end
        r_rdata_x <= r_mem_x[i_raddr];
        r_rdata_y <= r_mem_y[i_raddr];
        r_rdata_z <= r_mem_z[i_raddr];
    end

    assign o_rdata_x = r_rdata_x;
    assign o_rdata_y = r_rdata_y;
    assign o_rdata_z = r_rdata_z;

endmodule

/* rtl/bezier_bernstein_curve_eval.sv */
// bezier curve evaluator in bernstein form: point store, sequencer, shared multiplier
// next-point request with count points, n = count-1: the (1-t) powers are built first,
// then each of the n+1 terms goes through the one multiplier, then the sums are finished
// no points or finished sweep: no terms are computed; load and restart leave the sequencer idle
// throughput: one request at a time, ready again as the result goes valid, longer if it waits
// synchronous active-low reset clears count, t, overflow and sets step_size to 655
module bezier_bernstein_curve_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic                i_first_point,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_curve_x,
    output logic signed [31:0]  o_curve_y,
    output logic signed [31:0]  o_curve_z,
    output logic [1:0]          o_status,
    output logic                o_last,
    output logic                o_overflow
);

    localparam int MAXP   = bez_pkg::MAX_POINTS;
    localparam int IW     = bez_pkg::IDX_W;
    localparam int CW     = bez_pkg::CNT_W;
    localparam int QW     = bez_pkg::Q_W;
    localparam int WW     = bez_pkg::WGT_W;
    localparam int AW     = bez_pkg::ACC_W;
    localparam int MW     = bez_pkg::MUL_W;
    localparam int PW     = bez_pkg::PROD_W;
    localparam int SW     = bez_pkg::SWEEP_W;
    localparam int PTW    = bez_pkg::PT_W;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_UPOW_ISS = 12'b0000_0000_0010,
        S_UPOW_WB  = 12'b0000_0000_0100,
        S_B        = 12'b0000_0000_1000,
        S_TP       = 12'b0000_0001_0000,
        S_C        = 12'b0000_0010_0000,
        S_WAIT     = 12'b0000_0100_0000,
        S_PX       = 12'b0000_1000_0000,
        S_PY       = 12'b0001_0000_0000,
        S_PZ       = 12'b0010_0000_0000,
        S_FIN      = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_UPOW,
        TAG_BVAL,
        TAG_TPOW,
        TAG_WVAL,
        TAG_ACCX,
        TAG_ACCY,
        TAG_ACCZ
    } t_tag;

    t_state r_state, n_state;
    t_tag   r_tag, n_tag;

    logic [bez_pkg::STEP_W-1:0] r_step;
    logic [CW-1:0]              r_count;
    logic [SW-1:0]              r_sweep_t;
    logic                       r_ovf;
    logic                       r_out_valid;

    logic [IW-1:0]  r_deg;
    logic [IW-1:0]  r_i;
    logic [IW-1:0]  r_k;
    logic [IW-1:0]  r_wb_k;
    logic [QW-1:0]  r_upow [MAXP];
    logic [QW-1:0]  r_tp;
    logic [QW-1:0]  r_tq;
    logic [QW-1:0]  r_uq;
    logic [QW-1:0]  r_b;
    logic [WW-1:0]  r_w;
    logic [AW-1:0]  r_acc_x;
    logic [AW-1:0]  r_acc_y;
    logic [AW-1:0]  r_acc_z;
    logic [1:0]     r_res_status;

    logic signed [PTW-1:0] r_out_x;
    logic signed [PTW-1:0] r_out_y;
    logic signed [PTW-1:0] r_out_z;
    logic [1:0]            r_out_status;
    logic                  r_out_last;
    logic                  r_out_ovf;

    logic                  in_xfer;
    logic                  out_free;
    logic [CW-1:0]         eff_count;
    logic                  store_we;
    logic [QW-1:0]         t_q30;
    logic [IW-1:0]         upow_rd_idx;
    logic [IW-1:0]         deg_minus_i;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic [PW-1:0]         prod_u;
    logic [61:0]           rnd_sum;
    logic [QW-1:0]         rnd;
    logic [QW-1:0]         w_clamp;
    logic [QW:0]           w_sum;
    logic [SW-1:0]         next_t;
    logic signed [PTW-1:0] rd_x;
    logic signed [PTW-1:0] rd_y;
    logic signed [PTW-1:0] rd_z;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign eff_count = i_first_point ? '0 : r_count;
    assign store_we  = in_xfer && (i_req_type == bez_pkg::REQ_LOAD)
                       && (eff_count < CW'(MAXP));
    assign t_q30     = {r_sweep_t[16:0], 14'b0};

    assign upow_rd_idx = r_k - IW'(1);
    assign deg_minus_i = r_deg - r_i;

    assign prod_u  = prod;
    assign rnd_sum = prod_u[61:0] + 62'h2000_0000;
    assign rnd     = rnd_sum[60:30];
    assign w_clamp = (prod_u > PW'(bez_pkg::ONE_Q30)) ? bez_pkg::ONE_Q30 : prod_u[QW-1:0];
    assign w_sum   = {1'b0, w_clamp} + (QW+1)'(2);
    assign next_t  = r_sweep_t + SW'(r_step);

    bez_store u_store (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (eff_count[IW-1:0]),
        .i_wdata_x (i_point_x),
        .i_wdata_y (i_point_y),
        .i_wdata_z (i_point_z),
        .i_raddr   (r_i),
        .o_rdata_x (rd_x),
        .o_rdata_y (rd_y),
        .o_rdata_z (rd_z)
    );

    bez_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // sequencer and multiplier operand select
    always_comb begin
        n_state = r_state;
        n_tag   = TAG_NONE;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_req_type == bez_pkg::REQ_NEXT)) begin
                    if ((r_count == '0) || (r_sweep_t > bez_pkg::ONE_Q16)) begin
                        n_state = S_DONE;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_B;
                    end else begin
                        n_state = S_UPOW_ISS;
                    end
                end
            end
            S_UPOW_ISS: begin
                mul_a   = MW'(r_uq);
                mul_b   = MW'(r_upow[upow_rd_idx]);
                n_tag   = TAG_UPOW;
                n_state = S_UPOW_WB;
            end
            S_UPOW_WB: begin
                n_state = (r_k == r_deg) ? S_B : S_UPOW_ISS;
            end
            S_B: begin
                mul_a   = MW'(r_tp);
                mul_b   = MW'(r_upow[deg_minus_i]);
                n_tag   = TAG_BVAL;
                n_state = S_TP;
            end
            S_TP: begin
                mul_a   = MW'(r_tp);
                mul_b   = MW'(r_tq);
                n_tag   = TAG_TPOW;
                n_state = S_C;
            end
            S_C: begin
                mul_a   = MW'(bez_pkg::BINOM_TBL[r_deg][r_i]);
                mul_b   = MW'(r_b);
                n_tag   = TAG_WVAL;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_PX;
            end
            S_PX: begin
                mul_a   = MW'(rd_x);
                mul_b   = MW'(r_w);
                n_tag   = TAG_ACCX;
                n_state = S_PY;
            end
            S_PY: begin
                mul_a   = MW'(rd_y);
                mul_b   = MW'(r_w);
                n_tag   = TAG_ACCY;
                n_state = S_PZ;
            end
            S_PZ: begin
                mul_a   = MW'(rd_z);
                mul_b   = MW'(r_w);
                n_tag   = TAG_ACCZ;
                n_state = (r_i == r_deg) ? S_FIN : S_B;
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tag       <= TAG_NONE;
            r_step      <= bez_pkg::STEP_RESET;
            r_count     <= '0;
            r_sweep_t   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (in_xfer) begin
                case (i_req_type)
                    bez_pkg::REQ_LOAD: begin
                        if (eff_count >= CW'(MAXP)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count   <= eff_count + CW'(1);
                            r_sweep_t <= '0;
                        end
                    end
                    bez_pkg::REQ_RESTART: begin
                        r_sweep_t <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_res_status == bez_pkg::ST_VALID) begin
                    r_sweep_t <= next_t;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_req_type == bez_pkg::REQ_NEXT)) begin
            if (r_count == '0) begin
                r_res_status <= bez_pkg::ST_NO_POINTS;
            end else if (r_sweep_t > bez_pkg::ONE_Q16) begin
                r_res_status <= bez_pkg::ST_SWEEP_DONE;
            end else begin
                r_res_status <= bez_pkg::ST_VALID;
            end
            r_deg     <= IW'(r_count - CW'(1));
            r_tq      <= t_q30;
            r_uq      <= bez_pkg::ONE_Q30 - t_q30;
            r_tp      <= bez_pkg::ONE_Q30;
            r_upow[0] <= bez_pkg::ONE_Q30;
            r_k       <= IW'(1);
            r_i       <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_acc_z   <= '0;
        end
        if (r_state == S_UPOW_ISS) begin
            r_wb_k <= r_k;
        end
        if ((r_state == S_UPOW_WB) && (r_k != r_deg)) begin
            r_k <= r_k + IW'(1);
        end
        if ((r_state == S_PZ) && (r_i != r_deg)) begin
            r_i <= r_i + IW'(1);
        end
        case (r_tag)
            TAG_UPOW: r_upow[r_wb_k] <= rnd;
            TAG_BVAL: r_b <= rnd;
            TAG_TPOW: r_tp <= rnd;
            TAG_WVAL: r_w <= w_sum[QW-1:2];
            TAG_ACCX: r_acc_x <= r_acc_x + prod_u[AW-1:0];
            TAG_ACCY: r_acc_y <= r_acc_y + prod_u[AW-1:0];
            TAG_ACCZ: r_acc_z <= r_acc_z + prod_u[AW-1:0];
            default: begin
            end
        endcase
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_ovf    <= r_ovf;
            if (r_res_status == bez_pkg::ST_VALID) begin
                r_out_x    <= bez_pkg::finish(r_acc_x);
                r_out_y    <= bez_pkg::finish(r_acc_y);
                r_out_z    <= bez_pkg::finish(r_acc_z);
                r_out_last <= (next_t > bez_pkg::ONE_Q16);
            end else begin
                r_out_x    <= '0;
                r_out_y    <= '0;
                r_out_z    <= '0;
                r_out_last <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_curve_x   = r_out_x;
    assign o_curve_y   = r_out_y;
    assign o_curve_z   = r_out_z;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

/* tb/bezier_bernstein_curve_eval_tb.sv */
// testbench for bezier_bernstein_curve_eval: directed and random control-point
// loads and curve sweeps, checked against a bit-exact Q16.16 curve predictor
// depends on bez_pkg and the bezier_bernstein_curve_eval rtl
`timescale 1ns / 100ps

module bezier_bernstein_curve_eval_tb;

    localparam logic [1:0]         REQ_UNUSED = 2'd3;
    localparam logic signed [31:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN  = 32'sh8000_0000;
    localparam bit [63:0]          Q30        = 64'h4000_0000;
    localparam bit [63:0]          HALF_Q30   = 64'h2000_0000;
    localparam longint             SAT_HI     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint             SAT_LO     = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         status;
        logic               last;
        logic               ovf;
    } t_curve_pt;

    class curve_scoreboard;
        logic [16:0]        step = bez_pkg::STEP_RESET;
        logic signed [31:0] px[bez_pkg::MAX_POINTS];
        logic signed [31:0] py[bez_pkg::MAX_POINTS];
        logic signed [31:0] pz[bez_pkg::MAX_POINTS];
        int unsigned        count = 0;
        logic [17:0]        t = '0;
        bit                 ovf = 1'b0;
        t_curve_pt          expected[$];
        int unsigned        errors = 0;
        int unsigned        checked = 0;
        int unsigned        sweeps_done = 0;

        function bit [63:0] pow_q30(bit [63:0] base, int unsigned k);
            bit [63:0] r;
            int unsigned j;
            r = Q30;
            for (j = 0; j < k; j++) begin
                r = (r * base + HALF_Q30) >> 30;
            end
            return r;
        endfunction

        function bit [63:0] binom(int unsigned n, int unsigned i);
            bit [63:0] c;
            int unsigned k;
            c = 1;
            for (k = 0; k < i; k++) begin
                c = c * 64'(n - k) / 64'(k + 1);
            end
            return c;
        endfunction

        function logic [31:0] round_q16(longint acc);
            bit [63:0] ua;
            bit [63:0] q;
            longint    r;
            ua = 64'(acc) + 64'h8000_0000_0000_0000;
            q  = (ua + 64'h0800_0000) >> 28;
            r  = longint'(q) - 64'sh8_0000_0000;
            if (r > SAT_HI) begin
                r = SAT_HI;
            end else if (r < SAT_LO) begin
                r = SAT_LO;
            end
            return r[31:0];
        endfunction

        function t_curve_pt eval_point();
            t_curve_pt   p;
            bit [63:0]   tq;
            bit [63:0]   uq;
            bit [63:0]   b;
            bit [63:0]   w;
            longint      wq;
            longint      ax;
            longint      ay;
            longint      az;
            int unsigned n;
            int unsigned i;
            int unsigned nt;
            p = '0;
            p.ovf = ovf;
            if (count == 0) begin
                p.status = bez_pkg::ST_NO_POINTS;
                return p;
            end
            if (t > bez_pkg::ONE_Q16) begin
                p.status = bez_pkg::ST_SWEEP_DONE;
                return p;
            end
            n  = count - 1;
            tq = 64'(t) << 14;
            uq = Q30 - tq;
            ax = 0;
            ay = 0;
            az = 0;
            for (i = 0; i <= n; i++) begin
                b = (pow_q30(tq, i) * pow_q30(uq, n - i) + HALF_Q30) >> 30;
                w = binom(n, i) * b;
                if (w > Q30) begin
                    w = Q30;
                end
                wq = longint'((w + 2) >> 2);
                ax += longint'(px[i]) * wq;
                ay += longint'(py[i]) * wq;
                az += longint'(pz[i]) * wq;
            end
            p.x      = round_q16(ax);
            p.y      = round_q16(ay);
            p.z      = round_q16(az);
            p.status = bez_pkg::ST_VALID;
            nt       = int'(t) + int'(step);
            p.last   = (nt > bez_pkg::ONE_Q16);
            t        = nt[17:0];
            if (p.last) begin
                sweeps_done++;
            end
            return p;
        endfunction

        function void note_request(logic [1:0] req, logic fp, logic signed [31:0] x,
                                   logic signed [31:0] y, logic signed [31:0] z);
            case (req)
                bez_pkg::REQ_LOAD: begin
                    if (fp) begin
                        count = 0;
                    end
                    if (count >= bez_pkg::MAX_POINTS) begin
                        ovf = 1'b1;
                    end else begin
                        px[count] = x;
                        py[count] = y;
                        pz[count] = z;
                        count++;
                        t = '0;
                    end
                end
                bez_pkg::REQ_RESTART: t = '0;
                bez_pkg::REQ_NEXT:    expected = {expected, eval_point()};
                default: ;
            endcase
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_point(t_curve_pt got);
            t_curve_pt want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual x=%h y=%h z=%h status=%0d",
                         $time, got.x, got.y, got.z, got.status);
                return;
            end
            want = expected.pop_front();
            checked++;
            compare("curve_x", want.x, got.x);
            compare("curve_y", want.y, got.y);
            compare("curve_z", want.z, got.z);
            compare("status", 32'(want.status), 32'(got.status));
            compare("last", 32'(want.last), 32'(got.last));
            compare("overflow", 32'(want.ovf), 32'(got.ovf));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [16:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic               i_first_point;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_curve_x;
    logic signed [31:0] o_curve_y;
    logic signed [31:0] o_curve_z;
    logic [1:0]         o_status;
    logic               o_last;
    logic               o_overflow;

    curve_scoreboard sb = new();
    int unsigned     tx_idle_pct = 14;
    int unsigned     rx_idle_pct = 66;
    bit              hold_out_long = 1'b0;
    int unsigned     items_sent = 0;
    int unsigned     steps_written = 0;

    bezier_bernstein_curve_eval i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_first_point (i_first_point),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_curve_z     (o_curve_z),
        .o_status      (o_status),
        .o_last        (o_last),
        .o_overflow    (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random stalls and one long hold-off
    initial begin
        forever begin
            if (hold_out_long) begin
                hold_out_long = 1'b0;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_point({o_curve_x, o_curve_y, o_curve_z, o_status, o_last, o_overflow});
        end
    end

    function automatic logic [31:0] rand_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            return $urandom;
        end else if (r < 60) begin
            return 32'($signed($urandom_range(2097151)) - 1048576);
        end else if (r < 85) begin
            return 32'($signed($urandom_range(33554431)) - 16777216);
        end
        case ($urandom_range(4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic [16:0] pick_step();
        case ($urandom_range(7))
            0:       return 17'd65536;
            1:       return 17'd1;
            2:       return 17'($urandom_range(1, 65536));
            3:       return 17'(65536 >> $urandom_range(0, 8));
            4:       return 17'($urandom_range(8192, 65536));
            5:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(1024, 16384));
        endcase
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(1, 4);
        end else if (r < 90) begin
            return $urandom_range(5, 10);
        end
        return $urandom_range(11, 16);
    endfunction

    // call at a rising edge; returns at the edge of the transfer
    task automatic send_item(logic [1:0] req, logic fp, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_first_point <= fp;
        i_point_x     <= x;
        i_point_y     <= y;
        i_point_z     <= z;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req, fp, x, y, z);
        if (req != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic drain_results();
        int unsigned waited = 0;
        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_step(logic [16:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.step = value;
        steps_written++;
    endtask

    task automatic run_sequence();
        int unsigned npts;
        int unsigned nnext;
        int unsigned k;
        if ($urandom_range(99) < 82) begin
            npts = pick_count();
            for (k = 0; k < npts; k++) begin
                send_item(bez_pkg::REQ_LOAD, (k == 0) && ($urandom_range(99) < 90),
                          rand_coord(), rand_coord(), rand_coord());
            end
            nnext = $urandom_range(1, 40);
            for (k = 0; k < nnext && sb.t <= bez_pkg::ONE_Q16; k++) begin
                send_item(bez_pkg::REQ_NEXT, 1'($urandom_range(1)), rand_coord(),
                          rand_coord(), rand_coord());
                if ($urandom_range(99) < 4) begin
                    send_item(bez_pkg::REQ_RESTART, 1'($urandom_range(1)), rand_coord(),
                              rand_coord(), rand_coord());
                end
            end
            if ($urandom_range(99) < 30) begin
                send_item(bez_pkg::REQ_NEXT, 1'($urandom_range(1)), rand_coord(),
                          rand_coord(), rand_coord());
            end
        end else begin
            nnext = $urandom_range(1, 6);
            for (k = 0; k < nnext; k++) begin
                send_item(2'($urandom_range(3)), 1'($urandom_range(1)), rand_coord(),
                          rand_coord(), rand_coord());
            end
        end
    endtask

    initial begin
        int unsigned mode;
        int unsigned phase;
        int unsigned mode_end;
        int unsigned phase_end;
        int unsigned k;
        bit          paused_once;
        paused_once    = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_req_type    <= bez_pkg::REQ_NEXT;
        i_first_point <= 1'b0;
        i_point_x     <= '0;
        i_point_y     <= '0;
        i_point_z     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, ignored codes, single point, two points, then a full store and one load past it
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_RESTART, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(REQ_UNUSED, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(bez_pkg::REQ_LOAD, 1'b1, COORD_MAX, COORD_MIN, 32'sd0);
        send_item(bez_pkg::REQ_NEXT, 1'b1, '0, '0, '0);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_LOAD, 1'b0, COORD_MIN, COORD_MAX, -32'sd1);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_RESTART, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        for (k = 2; k < bez_pkg::MAX_POINTS; k++) begin
            send_item(bez_pkg::REQ_LOAD, 1'b0, COORD_MAX, COORD_MIN,
                      k[0] ? COORD_MAX : COORD_MIN);
        end
        send_item(bez_pkg::REQ_LOAD, 1'b0, 32'sd1, 32'sd1, 32'sd1);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);

        // whole-range step, zero step and the widest step
        apply_step(17'd65536);
        send_item(bez_pkg::REQ_RESTART, 1'b0, '0, '0, '0);
        for (k = 0; k < 3; k++) send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        apply_step(17'd0);
        send_item(bez_pkg::REQ_RESTART, 1'b0, '0, '0, '0);
        for (k = 0; k < 2; k++) send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);
        apply_step(17'h1FFFF);
        send_item(bez_pkg::REQ_RESTART, 1'b0, '0, '0, '0);
        for (k = 0; k < 2; k++) send_item(bez_pkg::REQ_NEXT, 1'b0, '0, '0, '0);

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 66;
                end
                1: begin
                    tx_idle_pct = 66;
                    rx_idle_pct = 14;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            mode_end = items_sent + 550;
            phase = 0;
            while (items_sent < mode_end) begin
                apply_step(pick_step());
                phase_end = items_sent + $urandom_range(60, 140);
                if (mode == 0 && phase == 1) begin
                    hold_out_long = 1'b1;
                end
                while (items_sent < phase_end && items_sent < mode_end) begin
                    run_sequence();
                    if (mode == 1 && phase == 1 && !paused_once) begin
                        drain_results();
                        paused_once = 1'b1;
                    end
                end
                phase++;
            end
        end

        drain_results();
        if (sb.expected.size() != 0) begin
            $display("%0t: %0d curve points never arrived", $time, sb.expected.size());
            sb.errors += sb.expected.size();
        end
        $display("ran %0d requests over %0d step settings, with saturation and store overflow",
                 items_sent, steps_written);
        $display("checked %0d curve points, %0d sweeps reached their end, %0d errors",
                 sb.checked, sb.sweeps_done, sb.errors);
        if (sb.errors == 0) begin
            $display("bezier_bernstein_curve_eval_tb: PASS");
        end else begin
            $display("bezier_bernstein_curve_eval_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #24_000_000;
        $display("%0t: timeout", $time);
        $display("bezier_bernstein_curve_eval_tb: FAIL");
        $finish;
    end

endmodule
